@@ design/lsh_pkg.sv @@
// lsh_pkg: shared widths, register indexes, codes and the modulus mask helper
// for the grid hash block. No dependencies.
package lsh_pkg;

	localparam int COORD_W    = 32;
	localparam int SHIFT_W    = 16;
	localparam int TIDX_W     = 7;
	localparam int WW_W       = 16;
	localparam int HB_W       = 6;
	localparam int HASH_W     = 32;
	localparam int TDATA_W    = 56;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// serial divider: one quotient bit per cycle
	localparam int QUOT_W    = 32;
	localparam int DIV_CNT_W = 5;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_BITS    = 2'd1;

	localparam logic [WW_W-1:0] WW_RESET = 16'd4;
	localparam logic [HB_W-1:0] HB_RESET = 6'd8;

	// item kinds carried on tuser
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_COORD = 1'b1;

	// mask for modulus 2^bits, bits clamped to 1..32
	function automatic logic [HASH_W-1:0] hash_mask(input logic [HB_W-1:0] bits);
		logic [HB_W-1:0] eff;
		eff = bits;
		if (eff == '0) eff = HB_W'(1);
		if (eff > HB_W'(HASH_W)) eff = HB_W'(HASH_W);
		return {HASH_W{1'b1}} >> (HB_W'(HASH_W) - eff);
	endfunction

endpackage

@@ design/lsh_grid_hash_top.sv @@
// lsh_grid_hash_top: grid hash of a point streamed one coordinate per item.
// Uses lsh_pkg, lsh_ram (shift table) and lsh_div (serial floor divider).
// Load item: written at its accept edge, next item taken the cycle after.
// Coordinate item: ready low through read, division (32 quotient bits + done) and fold; next item waits.
// Last coordinate: hash valid from the edge ready returns; waits while output is full.
// Reset (arst_n low, async): control, counters, accumulator cleared; w = 4, 8 hash bits.
module lsh_grid_hash_top #(
	parameter int MAX_DIMS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lsh_pkg::TDATA_W-1:0]     s_axis_tdata,  // coordinate[31:0], shift_value[47:32],
	                                                       // table_index[54:48], pad[55]
	input  logic                            s_axis_tuser,  // action: 0 load, 1 coordinate
	input  logic                            s_axis_tlast,  // last coordinate of the point
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lsh_pkg::HASH_W-1:0]      m_axis_tdata,  // hash_value[31:0]
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                         state_q;
	logic [AW-1:0]                  dim_cnt_q;
	logic [lsh_pkg::HASH_W-1:0]     acc_q;
	logic                           out_valid_q;
	logic [lsh_pkg::HASH_W-1:0]     out_data_q;
	logic [lsh_pkg::WW_W-1:0]       ww_q;
	logic [lsh_pkg::HB_W-1:0]       hb_q;

	// payload of the coordinate in flight
	logic [lsh_pkg::COORD_W-1:0]    coord_q;
	logic                           last_q;
	logic                           neg_q;
	logic [lsh_pkg::HASH_W-1:0]     neg5_q;

	logic                           s_acc;
	logic [lsh_pkg::COORD_W-1:0]    in_coord;
	logic [lsh_pkg::SHIFT_W-1:0]    in_shift;
	logic [lsh_pkg::TIDX_W-1:0]     in_tidx;
	logic [31:0]                    tidx_ext;
	logic                           idx_ok;
	logic                           tbl_we;
	logic [lsh_pkg::SHIFT_W-1:0]    tbl_rdata;

	logic [lsh_pkg::COORD_W:0]      diff;
	logic [lsh_pkg::QUOT_W-1:0]     dividend;
	logic [lsh_pkg::WW_W-1:0]       w_eff;
	logic [lsh_pkg::HASH_W-1:0]     mask;
	logic [lsh_pkg::HASH_W-1:0]     acc_m;
	logic [lsh_pkg::HASH_W-1:0]     neg5;
	logic                           div_start;
	logic                           div_done;
	logic [lsh_pkg::QUOT_W-1:0]     div_quot;
	logic [lsh_pkg::HASH_W-1:0]     q32;
	logic [lsh_pkg::HASH_W-1:0]     hash_new;
	logic                           out_free;
	logic                           fin_emit;
	logic [AW-1:0]                  dim_next;

	// ---- input unpack and handshakes
	assign s_acc    = s_axis_tvalid & s_axis_tready;
	assign in_coord = s_axis_tdata[31:0];
	assign in_shift = s_axis_tdata[47:32];
	assign in_tidx  = s_axis_tdata[54:48];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// loads past the table end are dropped
	assign tidx_ext = 32'(in_tidx);
	assign idx_ok   = tidx_ext < MAX_DIMS;
	assign tbl_we   = s_acc && (s_axis_tuser == lsh_pkg::ACT_LOAD) && idx_ok;

	// shift table; read address is the dimension counter, data valid in ST_READ
	lsh_ram #(
		.WIDTH (lsh_pkg::SHIFT_W),
		.DEPTH (MAX_DIMS)
	) u_shift_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tidx_ext[AW-1:0]),
		.wdata (in_shift),
		.raddr (dim_cnt_q),
		.rdata (tbl_rdata)
	);

	// ---- floor division setup
	// floor(d/w) for d < 0 equals ~floor(~d / w), and ~d fits 32 bits unsigned
	assign diff     = {coord_q[lsh_pkg::COORD_W-1], coord_q}
	                  - {{(lsh_pkg::COORD_W + 1 - lsh_pkg::SHIFT_W){1'b0}}, tbl_rdata};
	assign dividend = diff[lsh_pkg::COORD_W] ? ~diff[lsh_pkg::QUOT_W-1:0]
	                                         : diff[lsh_pkg::QUOT_W-1:0];
	assign w_eff    = (ww_q == '0) ? lsh_pkg::WW_W'(1) : ww_q;
	assign div_start = (state_q == ST_READ);

	lsh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (w_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---- Horner fold: r = 2^32 - 5, so acc*r mod 2^32 = -5*acc
	assign mask     = lsh_pkg::hash_mask(hb_q);
	assign acc_m    = acc_q & mask;
	assign neg5     = '0 - ((acc_m << 2) + acc_m);
	assign q32      = neg_q ? ~div_quot : div_quot;
	assign hash_new = (q32 + neg5_q) & mask;

	assign out_free = !out_valid_q || m_axis_tready;
	assign fin_emit = (state_q == ST_FIN) && last_q && out_free;
	assign dim_next = (dim_cnt_q == AW'(MAX_DIMS - 1)) ? '0 : dim_cnt_q + 1'b1;

	// ---- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_cnt_q   <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			ww_q        <= lsh_pkg::WW_RESET;
			hb_q        <= lsh_pkg::HB_RESET;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					lsh_pkg::REG_WINDOW_WIDTH: ww_q <= cfg_data;
					lsh_pkg::REG_HASH_BITS:    hb_q <= cfg_data[lsh_pkg::HB_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && m_axis_tready && !fin_emit) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_axis_tuser == lsh_pkg::ACT_COORD)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						acc_q     <= hash_new;
						dim_cnt_q <= dim_next;
						state_q   <= ST_IDLE;
					end else if (out_free) begin
						// hash goes out, point state starts over
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						dim_cnt_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			coord_q <= in_coord;
			last_q  <= s_axis_tlast;
		end
		if (state_q == ST_READ) begin
			neg_q  <= diff[lsh_pkg::COORD_W];
			neg5_q <= neg5;
		end
		if ((state_q == ST_FIN) && last_q && out_free) begin
			out_data_q <= hash_new;
		end
	end

`ifndef SYNTH
	// dimension counter stays inside the table
	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(dim_cnt_q) < MAX_DIMS)
		else $error("dimension counter beyond table depth");

	// divider finishes only while the FSM waits on it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside division state");

	// closing a point always presents a result the next cycle
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && last_q && out_free) |=> (m_axis_tvalid && (acc_q == '0)))
		else $error("last coordinate did not emit a hash");
`endif

endmodule

@@ design/lsh_ram.sv @@
// lsh_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/lsh_div.sv @@
// lsh_div: restoring unsigned divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle. Uses lsh_pkg.
module lsh_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lsh_pkg::QUOT_W-1:0]    dividend,
	input  logic [lsh_pkg::WW_W-1:0]      divisor,
	output logic                          done,
	output logic [lsh_pkg::QUOT_W-1:0]    quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [lsh_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [lsh_pkg::QUOT_W-1:0]     work_q;   // dividend bits out at top, quotient bits in at bottom
	logic [lsh_pkg::WW_W-1:0]       rem_q;
	logic [lsh_pkg::WW_W-1:0]       den_q;
	logic [lsh_pkg::WW_W:0]         trial;
	logic [lsh_pkg::WW_W:0]         diff;
	logic                           ge;

	assign trial = {rem_q, work_q[lsh_pkg::QUOT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lsh_pkg::DIV_CNT_W'(lsh_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[lsh_pkg::QUOT_W-2:0], ge};
			rem_q  <= ge ? diff[lsh_pkg::WW_W-1:0] : trial[lsh_pkg::WW_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule
